// File: rtl/direct_mapped_cache_tag_check_defines.svh
// assertion macros for the direct-mapped cache tag check
`ifndef DIRECT_MAPPED_CACHE_TAG_CHECK_DEFINES_SVH
`define DIRECT_MAPPED_CACHE_TAG_CHECK_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled while reset is asserted
`define DMC_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define DMC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmc assertion failed");

`else

`define DMC_ASSERT_SAME(name, clk, rst_n, ante, cons)
`define DMC_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/dmc_pkg.sv
// shared constants and types of the direct-mapped cache tag check
`timescale 1ns / 1ps

package dmc_pkg;

    // line store geometry
    localparam int MAX_LINES   = 1024;
    localparam int LINE_W      = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int INDEX_LIMIT = $clog2(MAX_LINES + 1) - 1;

    // field widths
    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int LINE_OUT_W = 10;
    localparam int COUNT_W    = 32;
    localparam int SHIFT_W    = 5;
    localparam int IDX_BITS_W = 4;
    localparam int EFF_W      = 5;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = CFG_IDX_W'(1);

    localparam logic [SHIFT_W-1:0]    BLOCK_SHIFT_RST = SHIFT_W'(4);
    localparam logic [IDX_BITS_W-1:0] INDEX_BITS_RST  = IDX_BITS_W'(6);
    localparam logic [EFF_W-1:0]      EFF_LIMIT       = EFF_W'(INDEX_LIMIT);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } queue_stat_t;

    typedef struct packed {
        logic clear_done;
        logic lookup;
    } back_stat_t;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } line_rec_t;

    localparam int REC_W = $bits(line_rec_t);

endpackage

// File: rtl/dmc_if.sv
// channel interfaces: lookup requests, lookup results, configuration writes
`timescale 1ns / 1ps

interface dmc_in_if;
    import dmc_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;
    modport source (output valid, output address, input ready);
    modport sink (input valid, input address, output ready);
endinterface

interface dmc_out_if;
    import dmc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [LINE_OUT_W-1:0] line_index;
    logic [TAG_W-1:0]      tag_value;
    logic [COUNT_W-1:0]    hit_count;
    logic [COUNT_W-1:0]    miss_count;
    modport source (output valid, output hit, output line_index, output tag_value,
                    output hit_count, output miss_count, input ready);
    modport sink (input valid, input hit, input line_index, input tag_value,
                  input hit_count, input miss_count, output ready);
endinterface

interface dmc_cfg_if;
    import dmc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/dmc_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/dmc_front.sv
// front end: configuration registers and address split into line and tag
`timescale 1ns / 1ps

module dmc_front (
    input  logic            clk,
    input  logic            rst_n,
    dmc_in_if.sink          lookup,
    dmc_cfg_if.sink         cfg,
    input  logic            accept_ok,
    output logic            push,
    output dmc_pkg::entry_t entry
);

    import dmc_pkg::*;

    logic [SHIFT_W-1:0]    block_shift_reg;
    logic [SHIFT_W-1:0]    block_shift_next;
    logic [IDX_BITS_W-1:0] index_bits_reg;
    logic [IDX_BITS_W-1:0] index_bits_next;
    logic [ADDR_W-1:0]     block_addr;
    logic [EFF_W-1:0]      idx_ext;
    logic [EFF_W-1:0]      eff;
    logic [ADDR_W-1:0]     line_mask;
    logic [ADDR_W-1:0]     line_full;

    // configuration writes, always taken
    assign cfg.ready = 1'b1;

    always_comb
    begin
        block_shift_next = block_shift_reg;
        index_bits_next  = index_bits_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BLOCK_SHIFT: block_shift_next = cfg.data[SHIFT_W-1:0];
                CFG_INDEX_BITS:  index_bits_next  = cfg.data[IDX_BITS_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_shift_reg <= BLOCK_SHIFT_RST;
            index_bits_reg  <= INDEX_BITS_RST;
        end
        else
        begin
            block_shift_reg <= block_shift_next;
            index_bits_reg  <= index_bits_next;
        end
    end

    // index width limited to the store
    assign idx_ext = EFF_W'(index_bits_reg);
    assign eff     = (idx_ext < EFF_LIMIT) ? idx_ext : EFF_LIMIT;

    // split of the block address
    assign block_addr = lookup.address >> block_shift_reg;
    assign line_mask  = (ADDR_W'(1) << eff) - ADDR_W'(1);
    assign line_full  = block_addr & line_mask;
    assign entry.line = LINE_W'(line_full);
    assign entry.tag  = TAG_W'(block_addr >> eff);

    // handshake
    assign lookup.ready = accept_ok;
    assign push         = lookup.valid && accept_ok;

endmodule

// File: rtl/dmc_queue.sv
// small fifo between the front end and the back end
`timescale 1ns / 1ps

module dmc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dmc_pkg::entry_t      push_entry,
    input  logic                 pop,
    output dmc_pkg::entry_t      head,
    output dmc_pkg::queue_stat_t stat
);

    import dmc_pkg::*;

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head           = slot_reg[rd_ptr_reg];
    assign stat.not_empty = (count_reg != '0);
    assign stat.not_full  = (count_reg != QCNT_W'(QUEUE_DEPTH));

endmodule

// File: rtl/dmc_back.sv
// back end: line store clear, tag lookup, line update, counters, result register
`timescale 1ns / 1ps

module dmc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dmc_pkg::entry_t      head,
    input  dmc_pkg::queue_stat_t qstat,
    output logic                 pop,
    output dmc_pkg::back_stat_t  stat,
    dmc_out_if.source            result
);

    import dmc_pkg::*;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [LINE_W-1:0]     clr_cnt_reg;
    logic [LINE_W-1:0]     clr_cnt_next;
    entry_t                cur_reg;
    entry_t                cur_next;
    logic [COUNT_W-1:0]    hit_cnt_reg;
    logic [COUNT_W-1:0]    hit_cnt_next;
    logic [COUNT_W-1:0]    miss_cnt_reg;
    logic [COUNT_W-1:0]    miss_cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  res_hit_reg;
    logic [LINE_OUT_W-1:0] res_line_reg;
    logic [TAG_W-1:0]      res_tag_reg;
    logic                  load_res;
    logic                  hit;
    logic                  out_free;
    logic                  ram_we;
    logic [LINE_W-1:0]     ram_waddr;
    line_rec_t             ram_wdata;
    logic                  ram_re;
    line_rec_t             ram_rdata;

    // line store: valid bit and tag per line
    dmc_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_LINES)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head.line),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || result.ready;
    assign hit      = ram_rdata.valid && (ram_rdata.tag == cur_reg.tag);

    // sequencer: clear pass, then read line, then resolve and write back on a miss
    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        cur_next      = cur_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        pop           = 1'b0;
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = cur_reg.line;
        ram_wdata     = '{valid: 1'b1, tag: cur_reg.tag};
        load_res      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == LINE_W'(MAX_LINES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (qstat.not_empty && out_free)
                begin
                    pop        = 1'b1;
                    ram_re     = 1'b1;
                    cur_next   = head;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                load_res   = 1'b1;
                state_next = ST_IDLE;
                if (hit)
                begin
                    if (hit_cnt_reg != '1)
                    begin
                        hit_cnt_next = hit_cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    ram_we = 1'b1;
                    if (miss_cnt_reg != '1)
                    begin
                        miss_cnt_next = miss_cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_res)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (load_res)
        begin
            res_hit_reg  <= hit;
            res_line_reg <= LINE_OUT_W'(cur_reg.line);
            res_tag_reg  <= cur_reg.tag;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.hit        = res_hit_reg;
    assign result.line_index = res_line_reg;
    assign result.tag_value  = res_tag_reg;
    assign result.hit_count  = hit_cnt_reg;
    assign result.miss_count = miss_cnt_reg;

    assign stat.clear_done = (state_reg != ST_CLEAR);
    assign stat.lookup     = (state_reg == ST_LOOKUP);

endmodule

// File: rtl/direct_mapped_cache_tag_check.sv
// top level of the direct-mapped cache tag check
//
// lookup: one transaction per byte address; the address is split into line
//   and tag under the block_shift and index_bits registers and queued.
// result: one transaction per lookup, in order: hit flag, line index, tag and
//   the running saturating hit and miss counts including this access.
// cfg: register writes (index 0 block_shift, index 1 index_bits), always
//   ready; other indexes are dropped. Write only while the block is idle.
// Flow: a lookup is queued, then popped while the back end is idle and its line
//   read from the line store, then resolved, written back on a miss and registered
//   as the result; no new lookup is popped before the last one is resolved.
// Reset: counters clear, configuration returns to 4 and 6, and a clear pass
//   walks the 1024-entry line store one line per cycle; lookup.ready stays
//   low until the pass is done.
// Stall: the result register holds until taken; the two-entry queue keeps
//   taking lookups and lookup.ready drops when it fills.
`timescale 1ns / 1ps

`include "direct_mapped_cache_tag_check_defines.svh"

module direct_mapped_cache_tag_check (
    input  logic      clk,
    input  logic      rst_n,
    dmc_in_if.sink    lookup,
    dmc_cfg_if.sink   cfg,
    dmc_out_if.source result
);

    import dmc_pkg::*;

    entry_t      push_entry;
    entry_t      head;
    logic        push;
    logic        pop;
    logic        accept_ok;
    queue_stat_t qstat;
    back_stat_t  bstat;

    // lookups held off during the clear pass and when the queue is full
    assign accept_ok = qstat.not_full && bstat.clear_done;

    dmc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .lookup    (lookup),
        .cfg       (cfg),
        .accept_ok (accept_ok),
        .push      (push),
        .entry     (push_entry)
    );

    dmc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (qstat)
    );

    dmc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .stat   (bstat),
        .result (result)
    );

    // checks
    `DMC_ASSERT_SAME(a_no_take_in_clear, clk, rst_n, push, bstat.clear_done)
    `DMC_ASSERT_SAME(a_pop_has_data, clk, rst_n, pop, qstat.not_empty)
    `DMC_ASSERT_NEXT(a_lookup_gives_result, clk, rst_n, bstat.lookup, result.valid)
    `DMC_ASSERT_SAME(a_push_has_room, clk, rst_n, push, qstat.not_full)

endmodule

// File: dv/direct_mapped_cache_tag_check_tb.sv
// self-checking testbench of the direct-mapped cache tag check
`timescale 1ns / 1ps

module direct_mapped_cache_tag_check_tb;
    import dmc_pkg::*;

    // spare configuration indexes, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 192;
    localparam int LONG_HOLD       = 100;
    localparam int HISTORY_DEPTH   = 16;

    typedef struct packed {
        logic                  hit;
        logic [LINE_OUT_W-1:0] line_index;
        logic [TAG_W-1:0]      tag_value;
        logic [COUNT_W-1:0]    hit_count;
        logic [COUNT_W-1:0]    miss_count;
    } lookup_result_t;

    logic clk = 1'b0;
    logic rst_n;

    dmc_in_if  lookup_ch ();
    dmc_out_if result_ch ();
    dmc_cfg_if cfg_ch ();

    direct_mapped_cache_tag_check dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .lookup (lookup_ch),
        .cfg    (cfg_ch),
        .result (result_ch)
    );

    // shadow copy of the tag store, counters and registers
    bit                    line_valid [MAX_LINES];
    logic [TAG_W-1:0]      line_tag [MAX_LINES];
    logic [COUNT_W-1:0]    hits_total;
    logic [COUNT_W-1:0]    misses_total;
    logic [SHIFT_W-1:0]    cur_block_shift;
    logic [IDX_BITS_W-1:0] cur_index_bits;

    logic [ADDR_W-1:0] pending_addresses [$];
    lookup_result_t    expected_results [$];
    logic [ADDR_W-1:0] recent_addrs [$];

    int mismatch_count = 0;
    int send_gap = 0;
    int stall_left = 0;
    bit quiet_mode = 1'b0;
    bit hold_request = 1'b0;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // lookup against the shadow store, updating it like the block does
    function automatic lookup_result_t cache_lookup(input logic [ADDR_W-1:0] address);
        logic [EFF_W-1:0]  eff;
        logic [ADDR_W-1:0] block_addr;
        logic [ADDR_W-1:0] line;
        lookup_result_t    res;
        eff = (cur_index_bits < INDEX_LIMIT) ? EFF_W'(cur_index_bits) : EFF_W'(INDEX_LIMIT);
        block_addr = address >> cur_block_shift;
        line = block_addr & ((32'h1 << eff) - 32'h1);
        res.tag_value = block_addr >> eff;
        res.hit = line_valid[line] && (line_tag[line] == res.tag_value);
        if (res.hit)
        begin
            if (hits_total != '1)
                hits_total = hits_total + 1'b1;
        end
        else
        begin
            line_valid[line] = 1'b1;
            line_tag[line] = res.tag_value;
            if (misses_total != '1)
                misses_total = misses_total + 1'b1;
        end
        res.line_index = line[LINE_OUT_W-1:0];
        res.hit_count = hits_total;
        res.miss_count = misses_total;
        return res;
    endfunction

    // address mix: reuse within a block, same line other tag, stride, fully random
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] offs_mask;
        logic [ADDR_W-1:0] addr;
        int                low_bit;
        int                eff;
        eff = (cur_index_bits < INDEX_LIMIT) ? int'(cur_index_bits) : INDEX_LIMIT;
        low_bit = int'(cur_block_shift) + eff;
        offs_mask = (32'h1 << cur_block_shift) - 32'h1;
        base = (recent_addrs.size() == 0) ? ADDR_W'($urandom)
             : recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
        case ($urandom_range(0, 9))
            0, 1, 2, 3: addr = (base & ~offs_mask) | (ADDR_W'($urandom) & offs_mask);
            4, 5: addr = (low_bit <= 31) ? base ^ (32'h1 << $urandom_range(31, low_bit)) : base;
            6: addr = recent_addrs.size() == 0 ? base
                    : recent_addrs[recent_addrs.size() - 1] + (32'h1 << cur_block_shift);
            default: addr = ADDR_W'($urandom);
        endcase
        recent_addrs.push_back(addr);
        if (recent_addrs.size() > HISTORY_DEPTH)
            void'(recent_addrs.pop_front());
        return addr;
    endfunction

    // wait until every lookup has been taken and answered
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_addresses.size() != 0 || expected_results.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    // one configuration transaction, shadow registers follow on acceptance
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_BLOCK_SHIFT: cur_block_shift = value[SHIFT_W-1:0];
            CFG_INDEX_BITS: cur_index_bits = value[IDX_BITS_W-1:0];
            default: ;
        endcase
    endtask

    // lookup driver: offers the head of the pending queue, pops it on acceptance
    always @(posedge clk)
    begin
        logic              nxt_valid;
        logic [ADDR_W-1:0] nxt_addr;
        if (!rst_n)
        begin
            lookup_ch.valid <= 1'b0;
            lookup_ch.address <= '0;
        end
        else
        begin
            nxt_valid = lookup_ch.valid;
            nxt_addr = lookup_ch.address;
            if (lookup_ch.valid && lookup_ch.ready)
            begin
                expected_results.push_back(cache_lookup(lookup_ch.address));
                void'(pending_addresses.pop_front());
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_addresses.size() != 0)
                begin
                    if (!quiet_mode && $urandom_range(0, 15) == 0)
                        send_gap = $urandom_range(1, 14);
                    else
                    begin
                        nxt_valid = 1'b1;
                        nxt_addr = pending_addresses[0];
                    end
                end
            end
            lookup_ch.valid <= nxt_valid;
            lookup_ch.address <= nxt_addr;
        end
    end

    // result monitor: compares each transaction with the oldest prediction
    always @(posedge clk)
    begin
        lookup_result_t got;
        lookup_result_t want;
        logic           nxt_ready;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.hit = result_ch.hit;
                got.line_index = result_ch.line_index;
                got.tag_value = result_ch.tag_value;
                got.hit_count = result_ch.hit_count;
                got.miss_count = result_ch.miss_count;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result transaction hit=%0d line=%0d tag=%h",
                                 $realtime, got.hit, got.line_index, got.tag_value);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: result mismatch exp hit=%0d line=%0d tag=%h ",
                                      "hits=%0d misses=%0d got hit=%0d line=%0d tag=%h ",
                                      "hits=%0d misses=%0d"}, $realtime,
                                     want.hit, want.line_index, want.tag_value,
                                     want.hit_count, want.miss_count,
                                     got.hit, got.line_index, got.tag_value,
                                     got.hit_count, got.miss_count);
                    end
                end
            end
            // backpressure: long hold on request, random short stalls otherwise
            if (stall_left > 0)
            begin
                stall_left--;
                nxt_ready = 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
                nxt_ready = 1'b0;
            end
            else if (!quiet_mode && $urandom_range(0, 15) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                nxt_ready = 1'b0;
            end
            else
                nxt_ready = 1'b1;
            result_ch.ready <= nxt_ready;
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [CFG_DATA_W-1:0] value;
        logic [SHIFT_W-1:0]    shift;
        rst_n <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data <= '0;
        for (int i = 0; i < MAX_LINES; i++)
        begin
            line_valid[i] = 1'b0;
            line_tag[i] = '0;
        end
        hits_total = '0;
        misses_total = '0;
        cur_block_shift = BLOCK_SHIFT_RST;
        cur_index_bits = INDEX_BITS_RST;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: cold miss, repeat hit, same block, conflicting tag
        pending_addresses.push_back(32'h0000_0000);
        pending_addresses.push_back(32'h0000_0000);
        pending_addresses.push_back(32'h0000_000F);
        pending_addresses.push_back(32'hFFFF_FFFF);
        pending_addresses.push_back(32'hFFFF_FFFF);
        pending_addresses.push_back(32'h0000_0400);
        pending_addresses.push_back(32'h0000_0000);
        // back-to-back accesses to one line
        pending_addresses.push_back(32'h0000_0010);
        pending_addresses.push_back(32'h0000_0014);
        pending_addresses.push_back(32'h0000_0410);
        pending_addresses.push_back(32'h0000_0010);
        pending_addresses.push_back(32'hAAAA_AAAA);
        pending_addresses.push_back(32'h5555_5555);
        wait_drained();

        // byte blocks and a single line, stored lines kept across the change
        write_register(CFG_BLOCK_SHIFT, {27'h5A5A5A5, 5'd0});
        write_register(CFG_INDEX_BITS, {28'hFFFFFFF, 4'd0});
        pending_addresses.push_back(32'h1234_5678);
        pending_addresses.push_back(32'h1234_5678);
        pending_addresses.push_back(32'h0000_0000);
        pending_addresses.push_back(32'hFFFF_FFFF);
        wait_drained();

        // widest shift, index bits beyond the store, dropped writes
        write_register(CFG_BLOCK_SHIFT, 32'hFFFF_FFFF);
        write_register(CFG_INDEX_BITS, 32'h0000_000F);
        write_register(CFG_SPARE_LO, 32'h0000_0000);
        write_register(CFG_SPARE_HI, 32'hFFFF_FFFF);
        pending_addresses.push_back(32'h8000_0000);
        pending_addresses.push_back(32'h7FFF_FFFF);
        pending_addresses.push_back(32'hFFFF_FFFF);
        pending_addresses.push_back(32'h0000_0000);
        wait_drained();

        // block shift of 16 and index bits at the store limit
        write_register(CFG_BLOCK_SHIFT, 32'd16);
        write_register(CFG_INDEX_BITS, 32'd10);
        pending_addresses.push_back(32'hFFFF_0000);
        pending_addresses.push_back(32'hFFFF_0000);
        pending_addresses.push_back(32'h03FF_0000);

        // random phases, each under its own geometry
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            quiet_mode = (p == RANDOM_PHASES - 1) || ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 5))
                0: shift = '0;
                1: shift = '1;
                2: shift = SHIFT_W'(16);
                default: shift = SHIFT_W'($urandom_range(0, 12));
            endcase
            value = $urandom;
            value[SHIFT_W-1:0] = shift;
            write_register(CFG_BLOCK_SHIFT, value);
            value = $urandom;
            value[IDX_BITS_W-1:0] = IDX_BITS_W'($urandom_range(0, 15));
            write_register(CFG_INDEX_BITS, value);
            if ($urandom_range(0, 2) == 0)
                write_register($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
            recent_addrs.delete();
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                pending_addresses.push_back(pick_address());
            // hold results off early so the block backs up into its input
            if (p == 0)
                hold_request = 1'b1;
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
